// ----- hw/rtl/dual_wavetable_interp_oscillator_defines.svh -----
// ----------------------------------------------------------------------------
// Dual wavetable oscillator assertion macros
// Shared assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_WAVETABLE_INTERP_OSCILLATOR_DEFINES_SVH
`define DUAL_WAVETABLE_INTERP_OSCILLATOR_DEFINES_SVH

// Same-cycle implication
`define DWIO_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define DWIO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dwio_pkg.sv -----
// ----------------------------------------------------------------------------
// dwio_pkg
// Constants, codes and shared types of the dual wavetable oscillator.
// ----------------------------------------------------------------------------
package dwio_pkg;

	// Table geometry (power of two: index and phase wrap by truncation)
	localparam int TABLE_SIZE = 1024;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int FRAC_W     = 16;
	localparam int PH_W       = IDX_W + FRAC_W;

	// Field widths
	localparam int KIND_W  = 2;
	localparam int RATE_W  = 24;
	localparam int MIX_W   = 24;
	localparam int ENTRY_W = 16;
	localparam int GAIN_W  = 16;

	// Arithmetic widths
	localparam int INTERP_W = 32;                  // a*(1-f)+b*f always fits
	localparam int PROD_W   = INTERP_W + GAIN_W + 1;
	localparam int RND_SH   = 31;
	localparam int SCALED_W = PROD_W - RND_SH;

	// APB
	localparam int APB_DW = 32;
	localparam int ADDR_W = 3;

	localparam logic [ADDR_W-3:0] REG_OUTPUT_GAIN = '0;
	localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'h8000;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_SAMPLE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WR_MAIN  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WR_PERC  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic cfg_wr;      // write output_gain
		logic smp_start;   // sample request accepted: read entry a, step phase
		logic wr_main;     // main table write
		logic wr_perc;     // percussive table write
		logic rd_next;     // read entry b
		logic interp;      // interpolate
		logic scale;       // apply gain
		logic load_out;    // round, mix, saturate into output register
	} dwio_cmd_t;

endpackage

// ----- hw/rtl/dual_wavetable_interp_oscillator.sv -----
// ----------------------------------------------------------------------------
// dual_wavetable_interp_oscillator
// Phase-accumulator oscillator reading a main and a percussive wavetable.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per accept.
//   kind selects a sample step or a write of one main or percussive entry.
//   Table writes and unused kinds complete on accept and produce no result.
//   A sample request yields one result on the output channel
//   (out_valid / out_stall). The two tables share one phase.
//   A sample holds off new requests until it has loaded its result, set by the
//   single read port of each table (two reads), the interpolation multiply and
//   the gain multiply. A new request is taken while a finished result still
//   waits; a stalled result holds and the next sample then waits in its final
//   stage. Reset clears the phase and sets output_gain to unity. Table contents
//   are undefined until written; there is no clearing pass. output_gain is
//   written over APB at byte address 0; the user must write it only while idle,
//   which the block itself does not enforce.
// ----------------------------------------------------------------------------
`include "dual_wavetable_interp_oscillator_defines.svh"

module dual_wavetable_interp_oscillator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dwio_pkg::KIND_W-1:0]         kind,
	input  logic [dwio_pkg::RATE_W-1:0]         rate,
	input  logic                                key_on,
	input  logic signed [dwio_pkg::MIX_W-1:0]   main_mix_in,
	input  logic signed [dwio_pkg::MIX_W-1:0]   perc_mix_in,
	input  logic [dwio_pkg::IDX_W-1:0]          entry_index,
	input  logic signed [dwio_pkg::ENTRY_W-1:0] entry_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [dwio_pkg::MIX_W-1:0]   main_out,
	output logic signed [dwio_pkg::MIX_W-1:0]   perc_out,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dwio_pkg::ADDR_W-1:0]         paddr,
	input  logic [dwio_pkg::APB_DW-1:0]         pwdata,
	output logic [dwio_pkg::APB_DW-1:0]         prdata,
	output logic                                pready
);

	dwio_pkg::dwio_cmd_t         cmd;
	logic [dwio_pkg::GAIN_W-1:0] gain;
	logic                        in_accept;

	dwio_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.cmd       (cmd)
	);

	dwio_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rate        (rate),
		.key_on      (key_on),
		.main_mix_in (main_mix_in),
		.perc_mix_in (perc_mix_in),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.gain_wdata  (pwdata[dwio_pkg::GAIN_W-1:0]),
		.gain        (gain),
		.main_out    (main_out),
		.perc_out    (perc_out)
	);

	// APB read-back
	assign pready = 1'b1;
	assign prdata = (paddr[dwio_pkg::ADDR_W-1:2] == dwio_pkg::REG_OUTPUT_GAIN) ?
	                dwio_pkg::APB_DW'(gain) : '0;

	assign in_accept = in_valid && !in_stall;

	// Checks
	`DWIO_ASSERT_NEXT(a_sample_busy, in_accept && kind == dwio_pkg::KIND_SAMPLE, in_stall, "sample request did not start the sequence")
	`DWIO_ASSERT_NEXT(a_write_single, in_accept && kind != dwio_pkg::KIND_SAMPLE, !in_stall, "non-sample request did not finish in one cycle")
	`DWIO_ASSERT_IMPL(a_latency, in_accept && kind == dwio_pkg::KIND_SAMPLE && !out_valid, ##5 out_valid, "sample result missing after five cycles")
	`DWIO_ASSERT_IMPL(a_no_cfg_busy, cmd.cfg_wr && cmd.smp_start, 1'b0, "config write in the same cycle as a sample request")

endmodule

// ----- hw/rtl/dwio_ctrl.sv -----
// ----------------------------------------------------------------------------
// dwio_ctrl
// Sequencer for one request at a time, output valid flag and APB decode.
// ----------------------------------------------------------------------------
module dwio_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [dwio_pkg::KIND_W-1:0]      kind,
	output logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dwio_pkg::ADDR_W-1:0]      paddr,
	output dwio_pkg::dwio_cmd_t              cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RDB    = 3'd1;
	localparam logic [2:0] ST_INTERP = 3'd2;
	localparam logic [2:0] ST_SCALE  = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       load;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load     = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && kind == dwio_pkg::KIND_SAMPLE) state_d = ST_RDB;
			end
			ST_RDB:    state_d = ST_INTERP;
			ST_INTERP: state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_OUT;
			ST_OUT: begin
				if (load) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// Commands
	always_comb begin
		cmd.cfg_wr    = psel && penable && pwrite &&
		                (paddr[dwio_pkg::ADDR_W-1:2] == dwio_pkg::REG_OUTPUT_GAIN);
		cmd.smp_start = accept && (kind == dwio_pkg::KIND_SAMPLE);
		cmd.wr_main   = accept && (kind == dwio_pkg::KIND_WR_MAIN);
		cmd.wr_perc   = accept && (kind == dwio_pkg::KIND_WR_PERC);
		cmd.rd_next   = (state_q == ST_RDB);
		cmd.interp    = (state_q == ST_INTERP);
		cmd.scale     = (state_q == ST_SCALE);
		cmd.load_out  = load;
	end

endmodule

// ----- hw/rtl/dwio_dp.sv -----
// ----------------------------------------------------------------------------
// dwio_dp
// Phase accumulator, both wavetables, interpolation, gain and saturating mix.
// ----------------------------------------------------------------------------
module dwio_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dwio_pkg::dwio_cmd_t                 cmd,
	input  logic [dwio_pkg::RATE_W-1:0]         rate,
	input  logic                                key_on,
	input  logic signed [dwio_pkg::MIX_W-1:0]   main_mix_in,
	input  logic signed [dwio_pkg::MIX_W-1:0]   perc_mix_in,
	input  logic [dwio_pkg::IDX_W-1:0]          entry_index,
	input  logic signed [dwio_pkg::ENTRY_W-1:0] entry_value,
	input  logic [dwio_pkg::GAIN_W-1:0]         gain_wdata,
	output logic [dwio_pkg::GAIN_W-1:0]         gain,
	output logic signed [dwio_pkg::MIX_W-1:0]   main_out,
	output logic signed [dwio_pkg::MIX_W-1:0]   perc_out
);

	localparam int ENTRY_W  = dwio_pkg::ENTRY_W;
	localparam int FRAC_W   = dwio_pkg::FRAC_W;
	localparam int PH_W     = dwio_pkg::PH_W;
	localparam int IDX_W    = dwio_pkg::IDX_W;
	localparam int INTERP_W = dwio_pkg::INTERP_W;
	localparam int PROD_W   = dwio_pkg::PROD_W;
	localparam int SCALED_W = dwio_pkg::SCALED_W;
	localparam int MIX_W    = dwio_pkg::MIX_W;
	localparam int LERP_W   = ENTRY_W + FRAC_W + 2;

	// a + (b - a) * f, with a scaled up by the fraction width
	function automatic logic signed [INTERP_W-1:0] lerp(
		input logic signed [ENTRY_W-1:0] a,
		input logic signed [ENTRY_W-1:0] b,
		input logic [FRAC_W-1:0]         f
	);
		logic signed [ENTRY_W:0]   d;
		logic signed [FRAC_W:0]    fs;
		logic signed [LERP_W-1:0]  prod;
		logic signed [LERP_W-1:0]  base;
		logic signed [LERP_W-1:0]  sum;
		d    = {b[ENTRY_W-1], b} - {a[ENTRY_W-1], a};
		fs   = {1'b0, f};
		prod = LERP_W'(d) * LERP_W'(fs);
		base = {{2{a[ENTRY_W-1]}}, a, {FRAC_W{1'b0}}};
		sum  = base + prod;
		return sum[INTERP_W-1:0];
	endfunction

	// Round to nearest (ties up), add into mix, saturate
	function automatic logic signed [MIX_W-1:0] mix_sat(
		input logic signed [MIX_W-1:0]  mix,
		input logic signed [PROD_W-1:0] q
	);
		logic signed [PROD_W-1:0]   t;
		logic signed [SCALED_W-1:0] s;
		logic signed [MIX_W:0]      sum;
		logic signed [MIX_W-1:0]    res;
		t   = q + (PROD_W'(1) <<< (dwio_pkg::RND_SH - 1));
		s   = t[PROD_W-1:dwio_pkg::RND_SH];
		sum = {mix[MIX_W-1], mix} + {{(MIX_W + 1 - SCALED_W){s[SCALED_W-1]}}, s};
		if (sum[MIX_W] != sum[MIX_W-1]) begin
			res = sum[MIX_W] ? {1'b1, {(MIX_W-1){1'b0}}} : {1'b0, {(MIX_W-1){1'b1}}};
		end else begin
			res = sum[MIX_W-1:0];
		end
		return res;
	endfunction

	logic [dwio_pkg::GAIN_W-1:0]       gain_q;
	logic [PH_W-1:0]                   phase_q;
	logic [PH_W-1:0]                   phase_eff;
	logic [PH_W:0]                     phase_sum;
	logic [IDX_W-1:0]                  rd_addr;
	logic [IDX_W-1:0]                  nxt_q;
	logic [FRAC_W-1:0]                 frac_q;
	logic signed [MIX_W-1:0]           main_mix_q;
	logic signed [MIX_W-1:0]           perc_mix_q;

	logic signed [ENTRY_W-1:0]         main_mem [dwio_pkg::TABLE_SIZE];
	logic signed [ENTRY_W-1:0]         perc_mem [dwio_pkg::TABLE_SIZE];
	logic signed [ENTRY_W-1:0]         main_rd_q;
	logic signed [ENTRY_W-1:0]         perc_rd_q;
	logic signed [ENTRY_W-1:0]         main_a_q;
	logic signed [ENTRY_W-1:0]         perc_a_q;

	logic signed [INTERP_W-1:0]        main_p_s1;
	logic signed [INTERP_W-1:0]        perc_p_s1;
	logic signed [PROD_W-1:0]          main_q_s2;
	logic signed [PROD_W-1:0]          perc_q_s2;
	logic signed [PROD_W-1:0]          main_prod;
	logic signed [PROD_W-1:0]          perc_prod;
	logic signed [dwio_pkg::GAIN_W:0]  gain_s;
	logic signed [MIX_W-1:0]           main_out_q;
	logic signed [MIX_W-1:0]           perc_out_q;

	// Gain register and phase accumulator
	assign phase_eff = key_on ? '0 : phase_q;
	assign phase_sum = {1'b0, phase_eff} + (PH_W + 1)'(rate >> 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= dwio_pkg::GAIN_RESET;
			phase_q <= '0;
		end else begin
			if (cmd.cfg_wr) gain_q <= gain_wdata;
			// table size is a power of two: wrap drops the carry
			if (cmd.smp_start) phase_q <= phase_sum[PH_W-1:0];
		end
	end

	assign gain = gain_q;

	// Capture of the sample request
	always_ff @(posedge clk) begin
		if (cmd.smp_start) begin
			frac_q     <= phase_eff[FRAC_W-1:0];
			nxt_q      <= phase_eff[PH_W-1:FRAC_W] + IDX_W'(1);
			main_mix_q <= main_mix_in;
			perc_mix_q <= perc_mix_in;
		end
	end

	// Table memories: one write or one registered read per cycle
	assign rd_addr = cmd.rd_next ? nxt_q : phase_eff[PH_W-1:FRAC_W];

	always_ff @(posedge clk) begin
		if (cmd.wr_main) main_mem[entry_index] <= entry_value;
		if (cmd.smp_start || cmd.rd_next) main_rd_q <= main_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_perc) perc_mem[entry_index] <= entry_value;
		if (cmd.smp_start || cmd.rd_next) perc_rd_q <= perc_mem[rd_addr];
	end

	// Hold entry a while entry b is read
	always_ff @(posedge clk) begin
		if (cmd.rd_next) begin
			main_a_q <= main_rd_q;
			perc_a_q <= perc_rd_q;
		end
	end

	// Interpolation stage
	always_ff @(posedge clk) begin
		if (cmd.interp) begin
			main_p_s1 <= lerp(main_a_q, main_rd_q, frac_q);
			perc_p_s1 <= lerp(perc_a_q, perc_rd_q, frac_q);
		end
	end

	// Gain stage
	assign gain_s    = {1'b0, gain_q};
	assign main_prod = PROD_W'(main_p_s1) * PROD_W'(gain_s);
	assign perc_prod = PROD_W'(perc_p_s1) * PROD_W'(gain_s);

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			main_q_s2 <= main_prod;
			perc_q_s2 <= perc_prod;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			main_out_q <= mix_sat(main_mix_q, main_q_s2);
			perc_out_q <= mix_sat(perc_mix_q, perc_q_s2);
		end
	end

	assign main_out = main_out_q;
	assign perc_out = perc_out_q;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual wavetable oscillator. The low entries of
// both tables are seeded first, and any entry a sample is about to read is
// written just before it, so no read hits an unwritten entry. Directed
// requests then cover midpoint rounding ties, saturation, ignored kinds and
// the phase wrap across the last entry. Gain settings go from zero to
// maximum, and random traffic runs with bursty input and random output
// stall. Each result is compared against an in-bench prediction of phase,
// tables and gain.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int KIND_W     = dwio_pkg::KIND_W;
	localparam int ADDR_W     = dwio_pkg::ADDR_W;
	localparam int TABLE_SIZE = dwio_pkg::TABLE_SIZE;
	localparam int FRAC_W     = dwio_pkg::FRAC_W;
	localparam int MIX_W      = dwio_pkg::MIX_W;
	localparam int RATE_W     = dwio_pkg::RATE_W;
	localparam int IDX_W      = dwio_pkg::IDX_W;
	localparam int ENTRY_W    = dwio_pkg::ENTRY_W;
	localparam int PH_W       = dwio_pkg::PH_W;
	localparam int GAIN_W     = dwio_pkg::GAIN_W;
	localparam int APB_DW     = dwio_pkg::APB_DW;

	localparam logic [KIND_W-1:0] KIND_SAMPLE  = dwio_pkg::KIND_SAMPLE;
	localparam logic [KIND_W-1:0] KIND_WR_MAIN = dwio_pkg::KIND_WR_MAIN;
	localparam logic [KIND_W-1:0] KIND_WR_PERC = dwio_pkg::KIND_WR_PERC;
	localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
	localparam logic [ADDR_W-1:0] GAIN_ADDR    = {dwio_pkg::REG_OUTPUT_GAIN, 2'b00};
	localparam longint PHASE_SPAN  = longint'(TABLE_SIZE) << FRAC_W;
	localparam int     STALL_LIMIT = 2000;
	localparam int     ITEMS       = 1700;
	localparam int     SEED_ROWS   = 64;
	localparam logic signed [MIX_W-1:0] MIX_MAX = 24'sh7FFFFF;
	localparam logic signed [MIX_W-1:0] MIX_MIN = 24'sh800000;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [RATE_W-1:0]         rate;
		logic                      key_on;
		logic signed [MIX_W-1:0]   main_mix;
		logic signed [MIX_W-1:0]   perc_mix;
		logic [IDX_W-1:0]          index;
		logic signed [ENTRY_W-1:0] value;
	} osc_req_t;

	typedef struct packed {
		logic signed [MIX_W-1:0] main_s;
		logic signed [MIX_W-1:0] perc_s;
	} mix_pair_t;

	// DUT signals
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [RATE_W-1:0] rate = '0;
	logic key_on = 1'b0;
	logic signed [MIX_W-1:0] main_mix_in = '0;
	logic signed [MIX_W-1:0] perc_mix_in = '0;
	logic [IDX_W-1:0] entry_index = '0;
	logic signed [ENTRY_W-1:0] entry_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [MIX_W-1:0] main_out;
	logic signed [MIX_W-1:0] perc_out;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	// Predicted oscillator state
	logic [PH_W-1:0] osc_phase = '0;
	logic signed [ENTRY_W-1:0] main_tab [TABLE_SIZE];
	logic signed [ENTRY_W-1:0] perc_tab [TABLE_SIZE];
	bit main_set [TABLE_SIZE];
	bit perc_set [TABLE_SIZE];
	logic [GAIN_W-1:0] gain_q = dwio_pkg::GAIN_RESET;
	mix_pair_t pending_mix [$];

	// Traffic shaping and bookkeeping
	int gap_max = 0;
	int burst_left = 0;
	int stall_max = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int n_sent = 0;
	int n_samples = 0;
	int n_writes = 0;
	int n_ignored = 0;
	int n_gains = 0;
	int n_mismatch = 0;

	dual_wavetable_interp_oscillator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .rate(rate), .key_on(key_on),
		.main_mix_in(main_mix_in), .perc_mix_in(perc_mix_in),
		.entry_index(entry_index), .entry_value(entry_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.main_out(main_out), .perc_out(perc_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One voice: interpolate, apply gain with round-half-up, add and saturate
	function automatic logic signed [MIX_W-1:0] mix_voice(
		input logic signed [ENTRY_W-1:0] a, b,
		input logic [FRAC_W-1:0] frac,
		input logic signed [MIX_W-1:0] mix_in,
		input logic [GAIN_W-1:0] g);
		longint fl, p, q, s, sum;
		fl = longint'(frac);
		p = longint'(a) * (65536 - fl) + longint'(b) * fl;
		q = p * longint'(g);
		s = (q + (longint'(1) <<< 30)) >>> 31;
		sum = longint'(mix_in) + s;
		if (sum > 8388607)
			sum = 8388607;
		if (sum < -8388608)
			sum = -8388608;
		return sum[MIX_W-1:0];
	endfunction

	// Apply one accepted request to the predicted state
	task automatic update_oscillator(input osc_req_t r);
		logic [IDX_W-1:0] i0, i1;
		logic [FRAC_W-1:0] f;
		mix_pair_t e;
		longint ph;
		case (r.kind)
			KIND_WR_MAIN: begin
				main_tab[r.index] = r.value;
				main_set[r.index] = 1'b1;
				n_writes++;
			end
			KIND_WR_PERC: begin
				perc_tab[r.index] = r.value;
				perc_set[r.index] = 1'b1;
				n_writes++;
			end
			KIND_SAMPLE: begin
				if (r.key_on)
					osc_phase = '0;
				i0 = osc_phase[PH_W-1:FRAC_W];
				f = osc_phase[FRAC_W-1:0];
				i1 = (i0 == TABLE_SIZE - 1) ? '0 : i0 + 1'b1;
				e.main_s = mix_voice(main_tab[i0], main_tab[i1], f, r.main_mix, gain_q);
				e.perc_s = mix_voice(perc_tab[i0], perc_tab[i1], f, r.perc_mix, gain_q);
				pending_mix.push_back(e);
				ph = longint'(osc_phase) + longint'(r.rate >> 2);
				if (ph >= PHASE_SPAN)
					ph -= PHASE_SPAN;
				osc_phase = ph[PH_W-1:0];
				n_samples++;
			end
			default: n_ignored++;
		endcase
	endtask

	// Drive one request; bursts of random length with random gaps between
	task automatic drive_req(input osc_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= r.kind;
		rate <= r.rate;
		key_on <= r.key_on;
		main_mix_in <= r.main_mix;
		perc_mix_in <= r.perc_mix;
		entry_index <= r.index;
		entry_value <= r.value;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		update_oscillator(r);
		n_sent++;
	endtask

	function automatic osc_req_t mk_write(input logic [KIND_W-1:0] k,
		input logic [IDX_W-1:0] idx, input logic signed [ENTRY_W-1:0] val);
		osc_req_t r;
		// fields a write ignores carry noise
		r.kind = k;
		r.rate = RATE_W'($urandom);
		r.key_on = 1'($urandom_range(0, 1));
		r.main_mix = MIX_W'($urandom);
		r.perc_mix = MIX_W'($urandom);
		r.index = idx;
		r.value = val;
		return r;
	endfunction

	// Send one request; a sample first gets any entry it reads written
	task automatic send_req(input osc_req_t r);
		logic [PH_W-1:0] ph0;
		logic [IDX_W-1:0] i0, i1;
		if (r.kind == KIND_SAMPLE) begin
			ph0 = r.key_on ? '0 : osc_phase;
			i0 = ph0[PH_W-1:FRAC_W];
			i1 = i0 + 1'b1;
			if (!main_set[i0])
				drive_req(mk_write(KIND_WR_MAIN, i0, ENTRY_W'($urandom)));
			if (!main_set[i1])
				drive_req(mk_write(KIND_WR_MAIN, i1, ENTRY_W'($urandom)));
			if (!perc_set[i0])
				drive_req(mk_write(KIND_WR_PERC, i0, ENTRY_W'($urandom)));
			if (!perc_set[i1])
				drive_req(mk_write(KIND_WR_PERC, i1, ENTRY_W'($urandom)));
		end
		drive_req(r);
	endtask

	// Stop sending, wait for every result, then let the pipeline settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_mix.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// APB write of output_gain followed by a readback
	task automatic set_gain(input logic [GAIN_W-1:0] g);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= GAIN_ADDR;
		pwdata <= {{(APB_DW - GAIN_W){1'b0}}, g};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		gain_q = g;
		n_gains++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {{(APB_DW - GAIN_W){1'b0}}, g}) begin
			$display("%0t output_gain readback: expected %0d actual %0d", $time, g, prdata);
			n_mismatch++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic signed [MIX_W-1:0] pick_mix();
		if ($urandom_range(0, 9) < 7)
			return MIX_W'($urandom);
		if ($urandom_range(0, 1))
			return MIX_MAX - MIX_W'($urandom_range(0, 65535));
		return MIX_MIN + MIX_W'($urandom_range(0, 65535));
	endfunction

	function automatic osc_req_t mk_sample(input logic key, input logic [RATE_W-1:0] rt,
		input logic signed [MIX_W-1:0] mm, pm);
		osc_req_t r;
		r.kind = KIND_SAMPLE;
		r.rate = rt;
		r.key_on = key;
		r.main_mix = mm;
		r.perc_mix = pm;
		r.index = IDX_W'($urandom);
		r.value = ENTRY_W'($urandom);
		return r;
	endfunction

	function automatic osc_req_t rand_req(input bit samples_only);
		osc_req_t r;
		int sel;
		logic [RATE_W-1:0] rt;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: rt = RATE_W'($urandom_range(0, 24'h3FFFF));
			5, 6, 7: rt = RATE_W'($urandom);
			8: rt = 24'hFFFFFF;
			default: rt = RATE_W'($urandom_range(0, 3));
		endcase
		r = mk_sample($urandom_range(0, 31) == 0, rt, pick_mix(), pick_mix());
		if ($urandom_range(0, 4) == 0)
			r.value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		if (!samples_only) begin
			sel = $urandom_range(0, 99);
			if (sel >= 97)
				r.kind = KIND_UNUSED;
			else if (sel >= 82)
				r.kind = KIND_WR_PERC;
			else if (sel >= 65)
				r.kind = KIND_WR_MAIN;
		end
		return r;
	endfunction

	// Receiver stall: alternating free and stalled runs of random length
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (stall_max == 0)
			out_stall <= 1'b0;
		else begin
			out_stall <= ~out_stall;
			stall_left = out_stall ? $urandom_range(0, 12) : $urandom_range(0, stall_max);
		end
	end

	// Result check against the oldest prediction
	always @(posedge clk) begin : result_check
		mix_pair_t e;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_mix.size() == 0) begin
				$display("%0t unexpected result: main_out %0d perc_out %0d",
					$time, main_out, perc_out);
				n_mismatch++;
			end else begin
				e = pending_mix.pop_front();
				if (main_out !== e.main_s) begin
					$display("%0t main_out: expected %0d actual %0d", $time, e.main_s, main_out);
					n_mismatch++;
				end
				if (perc_out !== e.perc_s) begin
					$display("%0t perc_out: expected %0d actual %0d", $time, e.perc_s, perc_out);
					n_mismatch++;
				end
			end
		end
	end

	// Watchdog: cycles with no request and no result accepted
	always @(posedge clk) begin
		if (arst_n && ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, pending_mix.size());
			$display("FAIL");
			$finish;
		end
	end

	// Seed the low entries of both tables with interleaved main and percussive writes
	task automatic test_fill_tables();
		gap_max = 2;
		for (int i = 0; i < SEED_ROWS; i++) begin
			send_req(mk_write(KIND_WR_MAIN, IDX_W'(i), ENTRY_W'($urandom)));
			send_req(mk_write(KIND_WR_PERC, IDX_W'(i), ENTRY_W'($urandom)));
		end
	endtask

	// Full-scale entries, midpoint tie, saturation, ignored kind
	task automatic test_directed_extremes();
		osc_req_t r;
		gap_max = 0;
		stall_max = 0;
		send_req(mk_write(KIND_WR_MAIN, IDX_W'(0), 16'sh7FFF));
		send_req(mk_write(KIND_WR_MAIN, IDX_W'(1), 16'sh8000));
		send_req(mk_write(KIND_WR_PERC, IDX_W'(0), 16'sh8000));
		send_req(mk_write(KIND_WR_PERC, IDX_W'(1), 16'sh7FFF));
		send_req(mk_sample(1'b1, 24'h020000, '0, '0));
		// unused kind must not clear phase or touch entry 0
		r = mk_write(KIND_UNUSED, IDX_W'(0), '0);
		r.key_on = 1'b1;
		send_req(r);
		send_req(mk_sample(1'b0, '0, MIX_MAX, MIX_MIN));
		send_req(mk_sample(1'b1, '0, MIX_MAX, MIX_MIN));
		send_req(mk_sample(1'b0, 24'd3, MIX_MIN, MIX_MAX));
		send_req(mk_sample(1'b0, 24'h7FFFFF, MIX_MIN, MIX_MAX));
		wait_idle();
	endtask

	// Largest step walks phase onto the last entry and wraps
	task automatic test_phase_wrap();
		gap_max = 1;
		stall_max = 3;
		send_req(mk_write(KIND_WR_MAIN, IDX_W'(TABLE_SIZE - 1), 16'sh8000));
		send_req(mk_write(KIND_WR_PERC, IDX_W'(TABLE_SIZE - 1), 16'sh7FFF));
		send_req(mk_sample(1'b1, 24'hFFFFFF, pick_mix(), pick_mix()));
		for (int k = 0; k < 18; k++)
			send_req(mk_sample(1'b0, 24'hFFFFFF, pick_mix(), pick_mix()));
		wait_idle();
	endtask

	// Gain extremes and a few values around unity
	task automatic test_gain_settings();
		logic [GAIN_W-1:0] gains [6];
		gains = '{16'd0, 16'd1, 16'd32767, 16'd32769, 16'hFFFF, 16'd0};
		gains[5] = GAIN_W'($urandom);
		gap_max = 3;
		stall_max = 6;
		foreach (gains[g]) begin
			set_gain(gains[g]);
			for (int k = 0; k < 10; k++)
				send_req(rand_req(1'b1));
			wait_idle();
		end
	endtask

	// Random traffic in phases, each with its own gain and idling profile
	task automatic test_random_traffic();
		int gaps [4];
		int stalls [4];
		logic [GAIN_W-1:0] gains [4];
		int span;
		int goal;
		gaps = '{0, 6, 20, 3};
		stalls = '{0, 4, 30, 12};
		gains = '{dwio_pkg::GAIN_RESET, 16'hFFFF, 16'd0, 16'd0};
		gains[2] = GAIN_W'($urandom);
		gains[3] = GAIN_W'($urandom_range(0, 16));
		span = (ITEMS - n_sent) / 4;
		for (int ph = 0; ph < 4; ph++) begin
			set_gain(gains[ph]);
			gap_max = gaps[ph];
			stall_max = stalls[ph];
			goal = ITEMS - (3 - ph) * span;
			while (n_sent < goal)
				send_req(rand_req(1'b0));
			// hold the sender until every result is back
			wait_idle();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_tables();
		test_directed_extremes();
		test_phase_wrap();
		test_gain_settings();
		test_random_traffic();
		wait_idle();
		$display("Checked %0d samples after %0d table writes and %0d ignored requests,",
			n_samples, n_writes, n_ignored);
		$display("across %0d gain settings with bursty input and random output stall.",
			n_gains);
		if (n_mismatch == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
